>>> design/spcd_pkg.sv
// Shared constants and register codes for the sliding-window PCA corner detector.
// No dependencies.
`timescale 1ns / 1ps

package spcd_pkg;

    localparam int MAX_WINDOW_DEF = 15;
    localparam int MAX_POINTS_DEF = 4096;

    localparam int COORD_W    = 16;
    localparam int WLEN_W     = 4;
    localparam int THR_W      = 25;
    localparam int GAP_W      = 12;
    localparam int OUT_IDX_W  = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 25;

    localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(5);
    localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(16777132);
    localparam logic [GAP_W-1:0]  GAP_RESET  = GAP_W'(17);

    localparam int PV_W = 25;
    localparam logic [PV_W-1:0] PV_ONE  = 25'h1000000;
    localparam logic [PV_W-1:0] PV_NONE = 25'h1FFFFFF;

    // covariance terms are scaled to below 2^NORM_W before the root
    localparam int NORM_W       = 30;
    localparam int MB_W         = 32;
    localparam int DIV_W        = 32;
    localparam int DCNT_W       = 6;
    localparam int PV_DIV_STEPS = 26;
    localparam int PV_FRAC_W    = 23;
    localparam int ROOT_W       = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_LENGTH      = 2'd0,
        REG_VARIANCE_THRESHOLD = 2'd1,
        REG_MERGE_GAP          = 2'd2
    } cfg_reg_t;

endpackage

>>> design/sliding_pca_corner_detector.sv
// Sliding-window PCA corner detector, top level.
// Depends on spcd_pkg.
`timescale 1ns / 1ps

// Usage:
//   s_ channel: one 2D point per item (s_point_x, s_point_y, s_last_point).
//   m_ channel: corner results (m_corner_index, m_has_corner, m_end_of_cloud).
//   cfg_we/cfg_index/cfg_data: register writes, only while the block is idle.
//   s_ready is high only while no point is in work. Once the window is full,
//   a point is taken, the window sums are rebuilt, the covariance is formed
//   and scaled, then the square root, the pv division (both skipped when the
//   scaled diagonal terms are zero) and the corner decision follow, all on one
//   shared multiplier / root / divider unit; before that, a point is just stored.
//   A closed corner group adds a divide of the group sum by its size and an
//   emit step; the last point of a cloud adds a close step (ST_FIN).
//   Results sit in an output register; a stalled receiver holds the block in
//   its emit step only when a second result is ready, otherwise the block
//   goes back to taking points at once.
//   Reset (aresetn low, synchronous) restores the register defaults and an
//   empty cloud. The last point of a cloud always yields a result with
//   m_end_of_cloud set and then clears all cloud state.
module sliding_pca_corner_detector #(
    parameter int MAX_WINDOW = spcd_pkg::MAX_WINDOW_DEF,
    parameter int MAX_POINTS = spcd_pkg::MAX_POINTS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [spcd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [spcd_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [spcd_pkg::COORD_W-1:0]  s_point_x,
    input  logic signed [spcd_pkg::COORD_W-1:0]  s_point_y,
    input  logic                                 s_last_point,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [spcd_pkg::OUT_IDX_W-1:0]       m_corner_index,
    output logic                                 m_has_corner,
    output logic                                 m_end_of_cloud
);
    import spcd_pkg::*;

    localparam int WB      = $clog2(MAX_WINDOW + 1);
    localparam int RW      = $clog2(MAX_WINDOW);
    localparam int IDX_W   = $clog2(MAX_POINTS);
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int SUM_W   = 2 * IDX_W;
    localparam int SZ_W    = IDX_W + 1;
    localparam int SX_W    = COORD_W + WB;
    localparam int SQ_W    = 2 * COORD_W + WB;
    localparam int AW      = 2 * SX_W + 1;
    localparam int MA_W    = SQ_W;
    localparam int PW      = MA_W + MB_W;
    localparam int LW      = (WB > WLEN_W) ? WB : WLEN_W;
    localparam int GW      = (IDX_W > GAP_W) ? IDX_W : GAP_W;
    localparam int GRP_SH  = DIV_W - SUM_W;

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b000_0000_0001,
        ST_ACC    = 11'b000_0000_0010,
        ST_COV    = 11'b000_0000_0100,
        ST_NORM   = 11'b000_0000_1000,
        ST_SQ     = 11'b000_0001_0000,
        ST_SQRT   = 11'b000_0010_0000,
        ST_PVSET  = 11'b000_0100_0000,
        ST_DIV    = 11'b000_1000_0000,
        ST_DECIDE = 11'b001_0000_0000,
        ST_FIN    = 11'b010_0000_0000,
        ST_EMIT   = 11'b100_0000_0000
    } state_t;

    state_t state_reg;

    logic [WLEN_W-1:0] cfg_wlen_reg;
    logic [THR_W-1:0]  cfg_thr_reg;
    logic [GAP_W-1:0]  cfg_gap_reg;

    logic signed [COORD_W-1:0] ring_x_reg [MAX_WINDOW];
    logic signed [COORD_W-1:0] ring_y_reg [MAX_WINDOW];
    logic [RW-1:0]    head_reg;
    logic [RW-1:0]    p_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [WB-1:0]    win_reg;
    logic [WB-1:0]    acc_i_reg;
    logic [2:0]       step_reg;
    logic [IDX_W-1:0] mid_reg;
    logic             last_reg;

    logic signed [COORD_W-1:0] xr_reg, yr_reg;
    logic signed [SX_W-1:0]    sx_reg, sy_reg;
    logic signed [SQ_W-1:0]    sxx_reg, syy_reg, sxy_reg;
    logic signed [PW-1:0]      prod_reg;
    logic signed [AW-1:0]      a_reg, b_reg, c_reg;
    logic [AW-1:0]             ua_reg, ub_reg, uc_reg;
    logic [NORM_W:0]           t_reg;
    logic [NORM_W-1:0]         diff_reg;
    logic [ROOT_W-1:0]         v_reg, r_reg, bit_reg;

    logic [DIV_W-1:0]  div_rem_reg, div_num_reg, div_den_reg, div_q_reg;
    logic [DCNT_W-1:0] div_cnt_reg;
    logic              div_pv_reg;

    logic [PV_W-1:0]  pv_new_reg, pv_before_reg, pv_mid_reg;
    logic             grp_open_reg;
    logic [SUM_W-1:0] grp_sum_reg;
    logic [SZ_W-1:0]  grp_size_reg;
    logic [IDX_W-1:0] grp_tail_reg;
    logic             emit_has_reg, emit_end_reg;

    logic                 m_valid_reg;
    logic [OUT_IDX_W-1:0] m_corner_index_reg;
    logic                 m_has_corner_reg, m_end_of_cloud_reg;

    // window length clamp, sampled at the first point of a cloud
    logic [LW-1:0] wl;
    logic [WB-1:0] w_clamp, w_use, half;
    always_comb begin
        wl = LW'(cfg_wlen_reg);
        if (wl < LW'(3)) begin
            wl = LW'(3);
        end else if (wl > LW'(MAX_WINDOW)) begin
            wl = LW'(MAX_WINDOW);
        end
        if (!wl[0]) begin
            wl = wl - LW'(1);
        end
        w_clamp = WB'(wl);
        w_use   = (cnt_reg == '0) ? w_clamp : win_reg;
        half    = (w_use - WB'(1)) >> 1;
    end

    logic signed [COORD_W-1:0] x_rd, y_rd;
    assign x_rd = ring_x_reg[p_reg];
    assign y_rd = ring_y_reg[p_reg];

    // shared multiplier operand select
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [MB_W-1:0] w_op;
    assign w_op = MB_W'(signed'({1'b0, win_reg}));
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_ACC: begin
                case (step_reg)
                    3'd0:    begin mul_a = MA_W'(x_rd);   mul_b = MB_W'(x_rd);   end
                    3'd1:    begin mul_a = MA_W'(yr_reg); mul_b = MB_W'(yr_reg); end
                    default: begin mul_a = MA_W'(xr_reg); mul_b = MB_W'(yr_reg); end
                endcase
            end
            ST_COV: begin
                case (step_reg)
                    3'd0:    begin mul_a = MA_W'(sxx_reg); mul_b = w_op;           end
                    3'd1:    begin mul_a = MA_W'(sx_reg);  mul_b = MB_W'(sx_reg);  end
                    3'd2:    begin mul_a = MA_W'(syy_reg); mul_b = w_op;           end
                    3'd3:    begin mul_a = MA_W'(sy_reg);  mul_b = MB_W'(sy_reg);  end
                    3'd4:    begin mul_a = MA_W'(sxy_reg); mul_b = w_op;           end
                    default: begin mul_a = MA_W'(sx_reg);  mul_b = MB_W'(sy_reg);  end
                endcase
            end
            ST_SQ: begin
                if (step_reg == 3'd0) begin
                    mul_a = MA_W'(signed'({1'b0, diff_reg}));
                    mul_b = MB_W'(signed'({1'b0, diff_reg}));
                end else begin
                    mul_a = MA_W'(signed'({1'b0, uc_reg[NORM_W-1:0]}));
                    mul_b = MB_W'(signed'({1'b0, uc_reg[NORM_W-1:0]}));
                end
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    logic signed [AW-1:0] c_fin;
    assign c_fin = c_reg - prod_reg[AW-1:0];

    logic scale_more;
    assign scale_more = |(ua_reg[AW-1:NORM_W] | ub_reg[AW-1:NORM_W] | uc_reg[AW-1:NORM_W]);

    logic [ROOT_W-1:0] rb;
    assign rb = r_reg + bit_reg;

    logic [NORM_W+1:0] td;
    assign td = {1'b0, t_reg} + (NORM_W+2)'(r_reg[NORM_W:0]);

    logic [DIV_W:0]   rem_sh;
    logic             div_ge;
    logic [DIV_W-1:0] q_nx;
    assign rem_sh = {div_rem_reg, div_num_reg[DIV_W-1]};
    assign div_ge = rem_sh >= {1'b0, div_den_reg};
    assign q_nx   = {div_q_reg[DIV_W-2:0], div_ge};

    logic             is_corner, joins;
    logic [IDX_W-1:0] gap_d;
    assign gap_d     = mid_reg - grp_tail_reg;
    assign joins     = grp_open_reg && (GW'(gap_d) < GW'(cfg_gap_reg));
    assign is_corner = (pv_mid_reg < pv_before_reg) && (pv_mid_reg < pv_new_reg)
                       && (PV_W'(pv_mid_reg) < cfg_thr_reg);

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cfg_wlen_reg  <= WLEN_RESET;
            cfg_thr_reg   <= THR_RESET;
            cfg_gap_reg   <= GAP_RESET;
            m_valid_reg   <= 1'b0;
            cnt_reg       <= '0;
            head_reg      <= '0;
            pv_before_reg <= PV_NONE;
            pv_mid_reg    <= PV_NONE;
            grp_open_reg  <= 1'b0;
            grp_sum_reg   <= '0;
            grp_size_reg  <= '0;
            grp_tail_reg  <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_index))
                    REG_WINDOW_LENGTH:      cfg_wlen_reg <= cfg_data[WLEN_W-1:0];
                    REG_VARIANCE_THRESHOLD: cfg_thr_reg  <= cfg_data[THR_W-1:0];
                    REG_MERGE_GAP:          cfg_gap_reg  <= cfg_data[GAP_W-1:0];
                    default: ;
                endcase
            end
            if (m_ready && state_reg != ST_EMIT) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        last_reg <= s_last_point;
                        if (cnt_reg < CNT_W'(MAX_POINTS)) begin
                            if (cnt_reg == '0) begin
                                win_reg <= w_clamp;
                            end
                            ring_x_reg[head_reg] <= s_point_x;
                            ring_y_reg[head_reg] <= s_point_y;
                            head_reg <= (head_reg == RW'(MAX_WINDOW - 1)) ? '0
                                        : head_reg + RW'(1);
                            p_reg     <= head_reg;
                            cnt_reg   <= cnt_reg + CNT_W'(1);
                            mid_reg   <= IDX_W'(cnt_reg - CNT_W'(half) - CNT_W'(1));
                            sx_reg    <= '0;
                            sy_reg    <= '0;
                            sxx_reg   <= '0;
                            syy_reg   <= '0;
                            sxy_reg   <= '0;
                            acc_i_reg <= '0;
                            step_reg  <= '0;
                            if (CNT_W'(cnt_reg + CNT_W'(1)) >= CNT_W'(w_use)) begin
                                state_reg <= ST_ACC;
                            end else if (s_last_point) begin
                                state_reg <= ST_FIN;
                            end
                        end else if (s_last_point) begin
                            state_reg <= ST_FIN;
                        end
                    end
                end

                ST_ACC: begin
                    case (step_reg)
                        3'd0: begin
                            xr_reg <= x_rd;
                            yr_reg <= y_rd;
                            sx_reg <= sx_reg + SX_W'(x_rd);
                            sy_reg <= sy_reg + SX_W'(y_rd);
                            if (acc_i_reg != '0) begin
                                sxy_reg <= sxy_reg + $signed(prod_reg[SQ_W-1:0]);
                            end
                            step_reg <= 3'd1;
                        end
                        3'd1: begin
                            sxx_reg  <= sxx_reg + $signed(prod_reg[SQ_W-1:0]);
                            step_reg <= 3'd2;
                        end
                        default: begin
                            syy_reg  <= syy_reg + $signed(prod_reg[SQ_W-1:0]);
                            step_reg <= 3'd0;
                            if (acc_i_reg == win_reg - WB'(1)) begin
                                state_reg <= ST_COV;
                            end else begin
                                acc_i_reg <= acc_i_reg + WB'(1);
                                p_reg <= (p_reg == '0) ? RW'(MAX_WINDOW - 1) : p_reg - RW'(1);
                            end
                        end
                    endcase
                end

                ST_COV: begin
                    if (step_reg < 3'd6) begin
                        step_reg <= step_reg + 3'd1;
                    end
                    case (step_reg)
                        3'd0: sxy_reg <= sxy_reg + $signed(prod_reg[SQ_W-1:0]);
                        3'd1: a_reg <= prod_reg[AW-1:0];
                        3'd2: a_reg <= a_reg - prod_reg[AW-1:0];
                        3'd3: b_reg <= prod_reg[AW-1:0];
                        3'd4: b_reg <= b_reg - prod_reg[AW-1:0];
                        3'd5: c_reg <= prod_reg[AW-1:0];
                        default: begin
                            ua_reg    <= a_reg[AW-1] ? '0 : a_reg;
                            ub_reg    <= b_reg[AW-1] ? '0 : b_reg;
                            uc_reg    <= c_fin[AW-1] ? -c_fin : c_fin;
                            step_reg  <= '0;
                            state_reg <= ST_NORM;
                        end
                    endcase
                end

                ST_NORM: begin
                    if (scale_more) begin
                        ua_reg <= ua_reg >> 1;
                        ub_reg <= ub_reg >> 1;
                        uc_reg <= uc_reg >> 1;
                    end else begin
                        t_reg <= {1'b0, ua_reg[NORM_W-1:0]} + {1'b0, ub_reg[NORM_W-1:0]};
                        diff_reg <= (ua_reg[NORM_W-1:0] > ub_reg[NORM_W-1:0])
                                    ? ua_reg[NORM_W-1:0] - ub_reg[NORM_W-1:0]
                                    : ub_reg[NORM_W-1:0] - ua_reg[NORM_W-1:0];
                        step_reg <= '0;
                        if (ua_reg[NORM_W-1:0] == '0 && ub_reg[NORM_W-1:0] == '0) begin
                            pv_new_reg <= PV_ONE;
                            state_reg  <= ST_DECIDE;
                        end else begin
                            state_reg <= ST_SQ;
                        end
                    end
                end

                ST_SQ: begin
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == 3'd1) begin
                        v_reg <= prod_reg[ROOT_W-1:0];
                    end else if (step_reg == 3'd2) begin
                        v_reg     <= v_reg + {prod_reg[ROOT_W-3:0], 2'b00};
                        r_reg     <= '0;
                        bit_reg   <= ROOT_W'(1) << (ROOT_W - 2);
                        state_reg <= ST_SQRT;
                    end
                end

                ST_SQRT: begin
                    if (v_reg >= rb) begin
                        v_reg <= v_reg - rb;
                        r_reg <= (r_reg >> 1) + bit_reg;
                    end else begin
                        r_reg <= r_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg[0]) begin
                        state_reg <= ST_PVSET;
                    end
                end

                ST_PVSET: begin
                    div_rem_reg <= DIV_W'(td >> 3);
                    div_num_reg <= {td[2:0], (DIV_W - 3)'(0)};
                    div_den_reg <= DIV_W'(t_reg);
                    div_q_reg   <= '0;
                    div_cnt_reg <= DCNT_W'(PV_DIV_STEPS);
                    div_pv_reg  <= 1'b1;
                    state_reg   <= ST_DIV;
                end

                ST_DIV: begin
                    div_rem_reg <= div_ge ? DIV_W'(rem_sh - {1'b0, div_den_reg})
                                          : DIV_W'(rem_sh);
                    div_num_reg <= div_num_reg << 1;
                    div_q_reg   <= q_nx;
                    div_cnt_reg <= div_cnt_reg - DCNT_W'(1);
                    if (div_cnt_reg == DCNT_W'(1)) begin
                        if (div_pv_reg) begin
                            pv_new_reg <= (q_nx > DIV_W'(PV_ONE)) ? PV_ONE : q_nx[PV_W-1:0];
                            state_reg  <= ST_DECIDE;
                        end else begin
                            state_reg <= ST_EMIT;
                        end
                    end
                end

                ST_DECIDE: begin
                    pv_before_reg <= pv_mid_reg;
                    pv_mid_reg    <= pv_new_reg;
                    if (is_corner && !joins && grp_open_reg) begin
                        state_reg <= ST_DIV;
                    end else begin
                        state_reg <= last_reg ? ST_FIN : ST_IDLE;
                    end
                    if (is_corner) begin
                        grp_tail_reg <= mid_reg;
                        if (joins) begin
                            grp_sum_reg  <= grp_sum_reg + SUM_W'(mid_reg);
                            grp_size_reg <= grp_size_reg + SZ_W'(1);
                        end else begin
                            if (grp_open_reg) begin
                                div_rem_reg  <= '0;
                                div_num_reg  <= DIV_W'(grp_sum_reg) << GRP_SH;
                                div_den_reg  <= DIV_W'(grp_size_reg);
                                div_q_reg    <= '0;
                                div_cnt_reg  <= DCNT_W'(SUM_W);
                                div_pv_reg   <= 1'b0;
                                emit_has_reg <= 1'b1;
                                emit_end_reg <= 1'b0;
                            end
                            grp_open_reg <= 1'b1;
                            grp_sum_reg  <= SUM_W'(mid_reg);
                            grp_size_reg <= SZ_W'(1);
                        end
                    end
                end

                ST_FIN: begin
                    emit_end_reg <= 1'b1;
                    if (grp_open_reg) begin
                        div_rem_reg  <= '0;
                        div_num_reg  <= DIV_W'(grp_sum_reg) << GRP_SH;
                        div_den_reg  <= DIV_W'(grp_size_reg);
                        div_q_reg    <= '0;
                        div_cnt_reg  <= DCNT_W'(SUM_W);
                        div_pv_reg   <= 1'b0;
                        emit_has_reg <= 1'b1;
                        state_reg    <= ST_DIV;
                    end else begin
                        emit_has_reg <= 1'b0;
                        state_reg    <= ST_EMIT;
                    end
                end

                ST_EMIT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg        <= 1'b1;
                        m_corner_index_reg <= emit_has_reg ? div_q_reg[OUT_IDX_W-1:0] : '0;
                        m_has_corner_reg   <= emit_has_reg;
                        m_end_of_cloud_reg <= emit_end_reg;
                        if (emit_end_reg) begin
                            cnt_reg       <= '0;
                            head_reg      <= '0;
                            pv_before_reg <= PV_NONE;
                            pv_mid_reg    <= PV_NONE;
                            grp_open_reg  <= 1'b0;
                            grp_sum_reg   <= '0;
                            grp_size_reg  <= '0;
                            grp_tail_reg  <= '0;
                            state_reg     <= ST_IDLE;
                        end else begin
                            state_reg <= last_reg ? ST_FIN : ST_IDLE;
                        end
                    end
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_corner_index = m_corner_index_reg;
    assign m_has_corner   = m_has_corner_reg;
    assign m_end_of_cloud = m_end_of_cloud_reg;

endmodule

>>> tb/sv/spcd_checker.sv
// Checker for the sliding-window PCA corner detector: watches both channels,
// predicts corner results from the accepted points and compares them.
// Depends on spcd_pkg.
`timescale 1ns / 1ps

module spcd_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [spcd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [spcd_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  logic signed [spcd_pkg::COORD_W-1:0]  s_point_x,
    input  logic signed [spcd_pkg::COORD_W-1:0]  s_point_y,
    input  logic                                 s_last_point,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  logic [spcd_pkg::OUT_IDX_W-1:0]       m_corner_index,
    input  logic                                 m_has_corner,
    input  logic                                 m_end_of_cloud,
    output int                                   error_count,
    output int                                   pending
);
    import spcd_pkg::*;

    localparam int RING = MAX_WINDOW_DEF;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] idx;
        logic                 has;
        logic                 eoc;
    } corner_t;

    corner_t corner_q[$];

    logic [WLEN_W-1:0] wlen_reg;
    logic [THR_W-1:0]  thr_reg;
    logic [GAP_W-1:0]  gap_reg;

    longint      ring_x[RING], ring_y[RING];
    int          head;
    int unsigned pt_count, win_lat;
    logic [PV_W-1:0] pv_prev, pv_mid;
    bit          grp_open;
    int unsigned grp_sum, grp_size, grp_tail;

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // pv of the newest win_lat points, Q1.24
    function automatic logic [PV_W-1:0] window_pv();
        longint sx, sy, sxx, syy, sxy, ca, cb, cc, x, y;
        logic [63:0] ua, ub, uc, mx, t, df, d, pv;
        int p, s;
        sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
        p = head;
        for (int i = 0; i < win_lat; i++) begin
            p = (p == 0) ? RING - 1 : p - 1;
            x = ring_x[p];
            y = ring_y[p];
            sx += x; sy += y; sxx += x * x; syy += y * y; sxy += x * y;
        end
        ca = longint'(win_lat) * sxx - sx * sx;
        cb = longint'(win_lat) * syy - sy * sy;
        cc = longint'(win_lat) * sxy - sx * sy;
        ua = (ca < 0) ? 0 : ca;
        ub = (cb < 0) ? 0 : cb;
        uc = (cc < 0) ? -cc : cc;
        mx = (ua > ub) ? ua : ub;
        if (uc > mx) mx = uc;
        s = 0;
        while (s < 63 && (mx >> s) >= (64'd1 << NORM_W)) s++;
        ua = ua >> s; ub = ub >> s; uc = uc >> s;
        t = ua + ub;
        if (t == 0) return PV_ONE;
        df = (ua > ub) ? ua - ub : ub - ua;
        d = int_sqrt(df * df + 4 * uc * uc);
        pv = ((t + d) << PV_FRAC_W) / t;
        return (pv > PV_ONE) ? PV_ONE : pv[PV_W-1:0];
    endfunction

    task automatic clear_cloud();
        for (int i = 0; i < RING; i++) begin
            ring_x[i] = 0;
            ring_y[i] = 0;
        end
        head = 0; pt_count = 0; win_lat = 5;
        pv_prev = PV_NONE; pv_mid = PV_NONE;
        grp_open = 0; grp_sum = 0; grp_size = 0; grp_tail = 0;
    endtask

    task automatic queue_result(corner_t c);
        corner_q = {corner_q, c};
    endtask

    task automatic absorb_point(logic signed [COORD_W-1:0] px,
                                logic signed [COORD_W-1:0] py, logic last);
        int unsigned n, mid, w;
        logic [PV_W-1:0] pv_new;
        if (pt_count < MAX_POINTS_DEF) begin
            n = pt_count;
            if (n == 0) begin
                w = wlen_reg;
                if (w < 3) w = 3;
                if (w > RING) w = RING;
                if (w % 2 == 0) w = w - 1;
                win_lat = w;
            end
            ring_x[head] = px;
            ring_y[head] = py;
            head = (head + 1 == RING) ? 0 : head + 1;
            pt_count = n + 1;
            if (pt_count >= win_lat) begin
                pv_new = window_pv();
                mid = n - (win_lat - 1) / 2 - 1;
                if (pv_mid < pv_prev && pv_mid < pv_new && pv_mid < thr_reg) begin
                    if (grp_open && mid - grp_tail < gap_reg) begin
                        grp_sum += mid;
                        grp_size++;
                    end else begin
                        if (grp_open)
                            queue_result('{OUT_IDX_W'(grp_sum / grp_size), 1'b1, 1'b0});
                        grp_open = 1;
                        grp_sum = mid;
                        grp_size = 1;
                    end
                    grp_tail = mid;
                end
                pv_prev = pv_mid;
                pv_mid = pv_new;
            end
        end
        if (last) begin
            if (grp_open && grp_size != 0)
                queue_result('{OUT_IDX_W'(grp_sum / grp_size), 1'b1, 1'b1});
            else
                queue_result('{'0, 1'b0, 1'b1});
            clear_cloud();
        end
    endtask

    always @(posedge aclk) begin
        corner_t exp_c;
        if (!aresetn) begin
            wlen_reg = WLEN_RESET;
            thr_reg = THR_RESET;
            gap_reg = GAP_RESET;
            clear_cloud();
            corner_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (corner_q.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("%0t: unexpected item idx=%0d has=%0b eoc=%0b", $realtime,
                                 m_corner_index, m_has_corner, m_end_of_cloud);
                end else begin
                    exp_c = corner_q.pop_front();
                    if (exp_c.idx !== m_corner_index || exp_c.has !== m_has_corner ||
                        exp_c.eoc !== m_end_of_cloud) begin
                        error_count++;
                        if (error_count <= 10)
                            $display("%0t: mismatch exp idx=%0d has=%0b eoc=%0b, got %0d %0b %0b",
                                     $realtime, exp_c.idx, exp_c.has, exp_c.eoc,
                                     m_corner_index, m_has_corner, m_end_of_cloud);
                    end
                end
            end
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_index))
                    REG_WINDOW_LENGTH:      wlen_reg = cfg_data[WLEN_W-1:0];
                    REG_VARIANCE_THRESHOLD: thr_reg = cfg_data[THR_W-1:0];
                    REG_MERGE_GAP:          gap_reg = cfg_data[GAP_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                absorb_point(s_point_x, s_point_y, s_last_point);
        end
        pending = corner_q.size();
    end

endmodule

>>> tb/sv/tb_top.sv
// Testbench top for the sliding-window PCA corner detector: drives point
// clouds and register settings, stalls the result side, reports the verdict.
// Depends on spcd_pkg, spcd_checker and sliding_pca_corner_detector.
`timescale 1ns / 1ps

module tb_top;
    import spcd_pkg::*;

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_we = 0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic s_valid = 0;
    logic s_ready;
    logic signed [COORD_W-1:0] s_point_x = '0, s_point_y = '0;
    logic s_last_point = 0;
    logic m_valid;
    logic m_ready = 0;
    logic [OUT_IDX_W-1:0] m_corner_index;
    logic m_has_corner, m_end_of_cloud;
    int error_count, pending;

    int burst_left = 0;
    int points_sent = 0;
    bit rx_free = 0;
    int rx_mode = 0, rx_left = 0, stall_left = 0;

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    sliding_pca_corner_detector uut (.*);

    spcd_checker chk (.*);

    // result side: modes of always-ready, random, and long stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 0;
        end else if (rx_free) begin
            m_ready <= 1;
        end else begin
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 2);
                rx_left = $urandom_range(200, 800);
            end
            rx_left--;
            case (rx_mode)
                0: m_ready <= 1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                default: begin
                    if (stall_left > 0) begin
                        m_ready <= 0;
                        stall_left--;
                    end else begin
                        m_ready <= 1;
                        if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 40);
                    end
                end
            endcase
        end
    end

    task automatic send_point(int px, int py, bit last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
            burst_left = $urandom_range(1, 16);
            if (gap > 0 && !rx_free) begin
                s_valid <= 0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid <= 1;
        s_point_x <= COORD_W'(px);
        s_point_y <= COORD_W'(py);
        s_last_point <= last;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        burst_left--;
        points_sent++;
    endtask

    task automatic wait_idle();
        s_valid <= 0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic set_config(int wl, int thr, int gap);
        wait_idle();
        cfg_we <= 1;
        cfg_index <= REG_WINDOW_LENGTH;
        cfg_data <= CFG_DATA_W'(wl);
        @(posedge aclk);
        cfg_index <= REG_VARIANCE_THRESHOLD;
        cfg_data <= CFG_DATA_W'(thr);
        @(posedge aclk);
        cfg_index <= REG_MERGE_GAP;
        cfg_data <= CFG_DATA_W'(gap);
        @(posedge aclk);
        cfg_we <= 0;
    endtask

    // kind 0: polyline with turns and jitter, 1: full-range noise, 2: one repeated point
    task automatic send_cloud(int len, int kind);
        int x, y, dx, dy, seg, jit;
        x = $urandom_range(0, 40000) - 20000;
        y = $urandom_range(0, 40000) - 20000;
        dx = $urandom_range(0, 600) - 300;
        dy = $urandom_range(0, 600) - 300;
        seg = $urandom_range(3, 20);
        jit = $urandom_range(0, 3) == 0 ? $urandom_range(0, 50) : 0;
        for (int i = 0; i < len; i++) begin
            case (kind)
                0: begin
                    if (seg == 0) begin
                        dx = $urandom_range(0, 600) - 300;
                        dy = $urandom_range(0, 600) - 300;
                        seg = $urandom_range(3, 20);
                    end
                    seg--;
                    x += dx;
                    y += dy;
                    send_point(x + $urandom_range(0, 2 * jit) - jit,
                               y + $urandom_range(0, 2 * jit) - jit, i == len - 1);
                end
                1: send_point($urandom(), $urandom(), i == len - 1);
                default: send_point(x, y, i == len - 1);
            endcase
        end
    endtask

    function automatic int pick_thr();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 1 << 24;
            2: return (1 << 25) - 1;
            3: return 16777132;
            default: return $urandom_range(1 << 23, 1 << 24);
        endcase
    endfunction

    initial begin
        int len, sel;
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: bare end marker, coordinate extremes, one clean corner
        send_point(0, 0, 1);
        send_point(-32768, -32768, 0);
        send_point(32767, 32767, 0);
        send_point(0, 0, 0);
        send_point(32767, -32768, 0);
        send_point(-32768, 32767, 1);
        for (int i = 0; i < 12; i++)
            send_point(i < 6 ? i * 100 : 500, i < 6 ? 0 : (i - 5) * 100, i == 11);

        // random clouds under changing settings
        sel = 0;
        while (points_sent < 1600) begin
            if (sel % 8 == 0) begin
                case ((sel / 8) % 4)
                    0: set_config($urandom_range(0, 15), pick_thr(), $urandom_range(0, 40));
                    1: set_config(15, 1 << 24, 4095);
                    2: set_config(3, pick_thr(), 1);
                    default: set_config($urandom_range(0, 15), pick_thr(), $urandom());
                endcase
            end
            sel++;
            case ($urandom_range(0, 9))
                0: len = $urandom_range(1, 4);
                1: len = $urandom_range(60, 200);
                default: len = $urandom_range(5, 60);
            endcase
            sel += 0;
            case ($urandom_range(0, 24))
                0, 1, 2: send_cloud(len, 1);
                3, 4: send_cloud(len, 2);
                default: send_cloud(len, 0);
            endcase
        end

        // closing cloud with an always-ready receiver, smallest window
        set_config(3, 1 << 24, 1);
        rx_free = 1;
        send_cloud(200, 0);

        s_valid <= 0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (300) @(posedge aclk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #30ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
